@@ sv/mgss_pkg.sv @@
// Shared constants and types for the modular geometric series sum core.
package mgss_pkg;

   localparam int unsigned VAL_BITS = 30;

   localparam logic [VAL_BITS-1:0] PRIME_MOD  = 30'd1000000007;
   localparam logic [VAL_BITS-1:0] FERMAT_EXP = PRIME_MOD - 30'd2;

   // Barrett constant floor(2^60 / P), used with a 29 bit and a 31 bit shift.
   localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

   localparam logic [31:0] PRIME_X1 = 32'd1000000007;
   localparam logic [31:0] PRIME_X2 = 32'd2000000014;
   localparam logic [31:0] PRIME_X3 = 32'd3000000021;
   localparam logic [31:0] PRIME_X4 = 32'd4000000028;

   typedef enum logic [1:0] {
      OP_ACC,
      OP_SQ,
      OP_NUM,
      OP_FIN
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_STEP,
      ST_SQUARE,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic {
      PH_POW,
      PH_INV
   } phase_type;

   typedef struct packed {
      logic   start;
      op_type tag;
   } mul_req_type;

   typedef struct packed {
      logic   done;
      logic   pending;
      op_type tag;
   } mul_rsp_type;

endpackage

@@ sv/modular_geometric_series_sum_core.sv @@
// Top level: geometric series sum x + x^2 + ... + x^n modulo 1000000007.
//
// A request beat carries a base and a term count; exactly one response beat
// carries the sum modulo the prime. req_stall is high from the accepting edge
// until the result has been moved into the response register, so one request
// is in work at a time. The response register lets a new request be taken
// while an earlier result still waits on a stalled receiver; a finished
// result that finds that register still full waits inside the block.
// Base zero, count zero, base one and a single term are settled in ST_PREP.
// Otherwise every modular multiply goes through one shared 5 stage Barrett
// multiplier, where the power's multiply and the squaring of an exponent bit
// overlap in the pipeline. The exponent loop runs over the bits of the count
// and then over the 30 bits of the Fermat exponent.
// The 30 bit loop is the Fermat inverse of base - 1.
// Synchronous reset empties the multiplier, returns the sequencer to idle
// and drops any pending response. A stalled response holds its value.
module modular_geometric_series_sum_core
   import mgss_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [29:0]         req_base,
   input  logic [31:0]         req_term_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [29:0]         rsp_series_sum
);

   localparam int NB = (COUNT_BITS < 32) ? COUNT_BITS : 32;
   localparam int EW = (NB > VAL_BITS) ? NB : VAL_BITS;

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [VAL_BITS-1:0] x_ff, x_in;
   logic [NB-1:0]       n_ff, n_in;
   logic [VAL_BITS-1:0] acc_ff, acc_in;
   logic [VAL_BITS-1:0] sq_ff, sq_in;
   logic [VAL_BITS-1:0] num_ff, num_in;
   logic [VAL_BITS-1:0] sum_ff, sum_in;
   logic [EW-1:0]       e_ff, e_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VAL_BITS-1:0] rsp_series_sum_ff;
   logic                rsp_load;

   mul_req_type         issue;
   mul_rsp_type         status;
   logic [VAL_BITS-1:0] op_a, op_b, mul_result;
   logic [VAL_BITS-1:0] base_red;
   logic [31:0]         n_wide;
   logic [31:0]         n_mod;

   mgss_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .op_a   (op_a),
      .op_b   (op_b),
      .status (status),
      .result (mul_result)
   );

   assign base_red = (req_base >= PRIME_MOD) ? (req_base - PRIME_MOD) : req_base;

   // The count is below 2^32, so at most four subtractions of P reduce it.
   assign n_wide = 32'(n_ff);
   always_comb begin
      if (n_wide >= PRIME_X4) begin
         n_mod = n_wide - PRIME_X4;
      end else if (n_wide >= PRIME_X3) begin
         n_mod = n_wide - PRIME_X3;
      end else if (n_wide >= PRIME_X2) begin
         n_mod = n_wide - PRIME_X2;
      end else if (n_wide >= PRIME_X1) begin
         n_mod = n_wide - PRIME_X1;
      end else begin
         n_mod = n_wide;
      end
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      x_in        = x_ff;
      n_in        = n_ff;
      acc_in      = acc_ff;
      sq_in       = sq_ff;
      num_in      = num_ff;
      sum_in      = sum_ff;
      e_in        = e_ff;
      issue.start = 1'b0;
      issue.tag   = OP_ACC;
      op_a        = acc_ff;
      op_b        = sq_ff;
      rsp_load    = 1'b0;
      req_stall   = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               x_in     = base_red;
               n_in     = req_term_count[NB-1:0];
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            if (x_ff == '0 || n_ff == '0) begin
               sum_in   = '0;
               state_in = ST_DONE;
            end else if (n_ff == NB'(1)) begin
               sum_in   = x_ff;
               state_in = ST_DONE;
            end else if (x_ff == VAL_BITS'(1)) begin
               sum_in   = n_mod[VAL_BITS-1:0];
               state_in = ST_DONE;
            end else begin
               acc_in   = VAL_BITS'(1);
               sq_in    = x_ff;
               e_in     = EW'(n_ff);
               phase_in = PH_POW;
               state_in = ST_STEP;
            end
         end

         ST_STEP: begin
            if (e_ff != '0) begin
               if (e_ff[0]) begin
                  issue.start = 1'b1;
                  issue.tag   = OP_ACC;
               end
               state_in = ST_SQUARE;
            end else begin
               issue.start = 1'b1;
               if (phase_ff == PH_POW) begin
                  // x^n is never zero here, so x^n - 1 needs no wrap.
                  issue.tag = OP_NUM;
                  op_a      = x_ff;
                  op_b      = acc_ff - VAL_BITS'(1);
               end else begin
                  issue.tag = OP_FIN;
                  op_a      = num_ff;
                  op_b      = acc_ff;
               end
               state_in = ST_WAIT;
            end
         end

         ST_SQUARE: begin
            e_in = e_ff >> 1;
            if (e_ff[EW-1:1] != '0) begin
               issue.start = 1'b1;
               issue.tag   = OP_SQ;
               op_a        = sq_ff;
               op_b        = sq_ff;
            end
            state_in = ST_WAIT;
         end

         ST_WAIT: begin
            if (status.done) begin
               case (status.tag)
                  OP_ACC: acc_in = mul_result;
                  OP_SQ:  sq_in  = mul_result;
                  OP_NUM: begin
                     num_in   = mul_result;
                     phase_in = PH_INV;
                     acc_in   = VAL_BITS'(1);
                     sq_in    = x_ff - VAL_BITS'(1);
                     e_in     = EW'(FERMAT_EXP);
                  end
                  OP_FIN: sum_in = mul_result;
                  default: sum_in = sum_ff;
               endcase
            end
            if (status.done && status.tag == OP_FIN) begin
               state_in = ST_DONE;
            end else if (!status.pending) begin
               state_in = ST_STEP;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_POW;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      n_ff   <= n_in;
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      num_ff <= num_in;
      sum_ff <= sum_in;
      e_ff   <= e_in;
      if (rsp_load) begin
         rsp_series_sum_ff <= sum_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_series_sum = rsp_series_sum_ff;

endmodule

@@ sv/mgss_mulmod.sv @@
// Five stage pipelined modular multiplier (Barrett reduction mod P).
module mgss_mulmod
   import mgss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  mul_req_type         issue,
   input  logic [VAL_BITS-1:0] op_a,
   input  logic [VAL_BITS-1:0] op_b,
   output mul_rsp_type         status,
   output logic [VAL_BITS-1:0] result
);

   logic [4:0]          valid_ff, valid_in;
   op_type              tag0_ff, tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [59:0]         prod_full, prod_ff;
   logic [61:0]         est_full;
   logic [30:0]         quot_ff;
   logic [60:0]         qp_full;
   logic [31:0]         lo1_ff, lo2_ff, qp_ff, rem_ff;
   logic [31:0]         fixed;
   logic [VAL_BITS-1:0] result_ff;

   assign prod_full = {30'd0, op_a} * {30'd0, op_b};
   assign est_full  = {31'd0, prod_ff[59:29]} * {31'd0, BARRETT_MU};
   assign qp_full   = {30'd0, quot_ff} * {31'd0, PRIME_MOD};

   // The quotient estimate is short by at most two, so the remainder stays below 3P.
   always_comb begin
      if (rem_ff >= PRIME_X2) begin
         fixed = rem_ff - PRIME_X2;
      end else if (rem_ff >= PRIME_X1) begin
         fixed = rem_ff - PRIME_X1;
      end else begin
         fixed = rem_ff;
      end
   end

   assign valid_in = {valid_ff[3:0], issue.start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag0_ff   <= issue.tag;
      tag1_ff   <= tag0_ff;
      tag2_ff   <= tag1_ff;
      tag3_ff   <= tag2_ff;
      tag4_ff   <= tag3_ff;
      prod_ff   <= prod_full;
      quot_ff   <= est_full[61:31];
      lo1_ff    <= prod_ff[31:0];
      qp_ff     <= qp_full[31:0];
      lo2_ff    <= lo1_ff;
      rem_ff    <= lo2_ff - qp_ff;
      result_ff <= fixed[VAL_BITS-1:0];
   end

   assign status.done    = valid_ff[4];
   assign status.pending = |valid_ff[3:0];
   assign status.tag     = tag4_ff;
   assign result         = result_ff;

endmodule

@@ sv/mgss_checker.sv @@
// Port level checker for the geometric series sum core, with its bind.
module mgss_checker
   import mgss_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [29:0] req_base,
   input logic [31:0] req_term_count,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [29:0] rsp_series_sum
);

   // A stalled response beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // A stalled response beat keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_series_sum))
      else $error("response payload changed while stalled");

   // Every sum leaves fully reduced.
   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_series_sum < PRIME_MOD)
      else $error("response sum not reduced modulo the prime");

   // An accepted request closes the input side; checked right after the accept.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side open right after an accept");

   // A new response only appears at the end of a busy period.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without work in progress");

endmodule

bind modular_geometric_series_sum_core mgss_checker u_mgss_checker (.*);
